### rtl/core/trfr_pkg.sv
// shared types and constants for the telemetry frame receiver
// no dependencies; imported by every module of the block
package trfr_pkg;

  // frame layout
  localparam logic [7:0] SYNC_BYTE      = 8'hEB;
  localparam logic [9:0] LEN_EXTRA      = 10'd6;
  localparam logic [9:0] POS_LEN_LO     = 10'd1;
  localparam logic [9:0] POS_LEN_HI     = 10'd2;
  localparam logic [9:0] POS_MIN_END    = 10'd3;
  localparam logic [9:0] POS_CODE       = 10'd4;
  localparam logic [9:0] POS_CNT_HI     = 10'd5;
  localparam logic [9:0] POS_CNT_LO     = 10'd6;
  localparam logic [9:0] POS_DATA_PRE   = 10'd8;
  localparam logic [9:0] POS_DATA       = 10'd9;

  // function codes
  localparam logic [7:0] CODE_DIGITAL   = 8'h05;
  localparam logic [7:0] CODE_ANALOG_A  = 8'h06;
  localparam logic [7:0] CODE_ANALOG_B  = 8'h07;
  localparam logic [7:0] CODE_HEARTBEAT = 8'h0B;
  localparam logic [7:0] CODE_STARTUP   = 8'h11;

  // link modes
  localparam logic [1:0] MODE_STARTUP   = 2'd1;
  localparam logic [1:0] MODE_HEARTBEAT = 2'd3;

  // analog point layout: six bytes per point, word in the first four
  localparam logic [2:0] PHASE_WORD_END = 3'd3;
  localparam logic [2:0] PHASE_LAST     = 3'd5;

  // point limits
  localparam int unsigned MAX_POINTS = 256;
  localparam int unsigned INDEX_CAP  = 256;
  localparam logic [8:0]  POINT_CAP  =
    9'((MAX_POINTS < INDEX_CAP) ? MAX_POINTS : INDEX_CAP);

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_DIGITAL  = 3'd0,
    KIND_ANALOG_A = 3'd1,
    KIND_ANALOG_B = 3'd2,
    KIND_DONE     = 3'd3,
    KIND_ABORT    = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  point_index;
    logic [31:0] point_value;
    logic [7:0]  frame_code;
    logic [9:0]  frame_bytes;
    logic [1:0]  link_mode;
    logic        last;
  } result_t;

  // up to two results from one word, r0 first
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

### rtl/core/trfr_parser.sv
// frame parser: per-word state update and result generation
// depends on trfr_pkg
module trfr_parser import trfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       func_i,
  input  logic [7:0] rx_byte_i,
  output push_t      push_o
);

  logic        in_frame_q, in_frame_d;
  logic [9:0]  byte_pos_q, byte_pos_d;
  logic [9:0]  frame_total_q, frame_total_d;
  logic [7:0]  code_reg_q, code_reg_d;
  logic [15:0] point_count_q, point_count_d;
  logic [8:0]  item_index_q, item_index_d;
  logic [31:0] value_accum_q, value_accum_d;
  logic [1:0]  send_mode_q, send_mode_d;
  logic [2:0]  phase_q, phase_d;

  logic        idx_ok;
  logic [9:0]  nxt_pos;
  result_t     upd;
  logic        upd_vld;
  push_t       push;

  assign idx_ok  = ({7'b0, item_index_q} < point_count_q) && (item_index_q < POINT_CAP);
  assign nxt_pos = byte_pos_q + 10'd1;

  // next state and results for one accepted word
  always_comb begin
    in_frame_d    = in_frame_q;
    byte_pos_d    = byte_pos_q;
    frame_total_d = frame_total_q;
    code_reg_d    = code_reg_q;
    point_count_d = point_count_q;
    item_index_d  = item_index_q;
    value_accum_d = value_accum_q;
    send_mode_d   = send_mode_q;
    phase_d       = phase_q;
    upd           = '0;
    upd_vld       = 1'b0;
    push          = '0;

    if (accept_i) begin
      if (func_i) begin
        // timeout aborts a partial frame
        if (in_frame_q) begin
          push.cnt            = 2'd1;
          push.r0.kind        = KIND_ABORT;
          push.r0.frame_code  = code_reg_q;
          push.r0.frame_bytes = byte_pos_q;
          in_frame_d          = 1'b0;
          byte_pos_d          = '0;
        end
      end else if (!in_frame_q) begin
        // hunting for sync
        if (rx_byte_i == SYNC_BYTE) begin
          in_frame_d    = 1'b1;
          byte_pos_d    = 10'd1;
          frame_total_d = '0;
          code_reg_d    = '0;
          point_count_d = '0;
          item_index_d  = '0;
          value_accum_d = '0;
        end
      end else begin
        // header fields
        if (byte_pos_q == POS_LEN_LO) begin
          frame_total_d = {2'b0, rx_byte_i};
        end else if (byte_pos_q == POS_LEN_HI) begin
          frame_total_d = {1'b0, rx_byte_i[0], frame_total_q[7:0]} + LEN_EXTRA;
        end else if (byte_pos_q == POS_CODE) begin
          code_reg_d = rx_byte_i;
        end else if (byte_pos_q == POS_CNT_HI) begin
          point_count_d = {rx_byte_i, 8'h00};
        end else if (byte_pos_q == POS_CNT_LO) begin
          point_count_d = {point_count_q[15:8], rx_byte_i};
        end else if (byte_pos_q >= POS_DATA) begin
          // point data
          if (code_reg_q == CODE_DIGITAL) begin
            if (byte_pos_q[0] && idx_ok) begin
              upd_vld          = 1'b1;
              upd.kind         = KIND_DIGITAL;
              upd.point_index  = item_index_q[7:0];
              upd.point_value  = {31'b0, rx_byte_i[7]};
              item_index_d     = item_index_q + 9'd1;
            end
          end else if (code_reg_q == CODE_ANALOG_A || code_reg_q == CODE_ANALOG_B) begin
            if (phase_q == 3'd0) begin
              value_accum_d = {24'b0, rx_byte_i};
            end else if (phase_q <= PHASE_WORD_END) begin
              value_accum_d = {value_accum_q[23:0], rx_byte_i};
            end
            if (phase_q == PHASE_WORD_END && idx_ok) begin
              upd_vld         = 1'b1;
              upd.kind        = (code_reg_q == CODE_ANALOG_A) ? KIND_ANALOG_A : KIND_ANALOG_B;
              upd.point_index = item_index_q[7:0];
              upd.point_value = value_accum_d;
              item_index_d    = item_index_q + 9'd1;
            end
          end
        end

        // analog byte phase within a point
        if (byte_pos_q == POS_DATA_PRE) begin
          phase_d = '0;
        end else if (byte_pos_q >= POS_DATA) begin
          phase_d = (phase_q == PHASE_LAST) ? 3'd0 : phase_q + 3'd1;
        end

        if (upd_vld) begin
          push.cnt = 2'd1;
          push.r0  = upd;
        end

        // end of frame
        byte_pos_d = nxt_pos;
        if (nxt_pos >= POS_MIN_END && nxt_pos == frame_total_d) begin
          if (code_reg_d == CODE_STARTUP) begin
            send_mode_d = MODE_STARTUP;
          end else if (code_reg_d == CODE_HEARTBEAT) begin
            send_mode_d = MODE_HEARTBEAT;
          end
          upd             = '0;
          upd.kind        = KIND_DONE;
          upd.frame_code  = code_reg_d;
          upd.frame_bytes = frame_total_d;
          upd.link_mode   = send_mode_d;
          if (push.cnt == 2'd0) begin
            push.r0 = upd;
          end else begin
            push.r1 = upd;
          end
          push.cnt   = push.cnt + 2'd1;
          in_frame_d = 1'b0;
          byte_pos_d = '0;
        end
      end
    end

    // mark the final result of this word
    push.r0.last = (push.cnt == 2'd1);
    push.r1.last = (push.cnt == 2'd2);
  end

  assign push_o = push;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      byte_pos_q    <= '0;
      frame_total_q <= '0;
      code_reg_q    <= '0;
      point_count_q <= '0;
      item_index_q  <= '0;
      value_accum_q <= '0;
      send_mode_q   <= '0;
      phase_q       <= '0;
    end else begin
      in_frame_q    <= in_frame_d;
      byte_pos_q    <= byte_pos_d;
      frame_total_q <= frame_total_d;
      code_reg_q    <= code_reg_d;
      point_count_q <= point_count_d;
      item_index_q  <= item_index_d;
      value_accum_q <= value_accum_d;
      send_mode_q   <= send_mode_d;
      phase_q       <= phase_d;
    end
  end

  // a second result is always the frame done word
  a_second_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt == 2'd2 |-> push.r1.kind == KIND_DONE && !push.r0.last)
    else $error("second result is not frame done");

  // nothing to report while hunting, except nothing
  a_hunt_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_frame_q && accept_i) |-> push.cnt == 2'd0)
    else $error("result while hunting");

  // hunting keeps the byte position at zero
  a_hunt_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> byte_pos_q == '0)
    else $error("byte position set while hunting");

endmodule

### rtl/core/trfr_result_fifo.sv
// small result queue, takes up to two words per cycle, gives one
// depends on trfr_pkg
module trfr_result_fifo import trfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output logic    full_o,
  output logic    valid_o,
  output result_t head_o
);

  result_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wptr_q, rptr_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [PTR_W-1:0]   wptr_nxt;

  assign wptr_nxt = wptr_q + PTR_W'(1);
  assign count_d  = count_q + CNT_W'(push_i.cnt) - CNT_W'(pop_i);

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wptr_nxt] <= push_i.r1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + PTR_W'(push_i.cnt);
      if (pop_i) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  // room for two words is needed before a new input word
  assign full_o  = count_q > CNT_W'(FIFO_DEPTH - 2);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> count_q <= CNT_W'(FIFO_DEPTH - 2))
    else $error("push without room for two words");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("queue level beyond depth");

endmodule

### rtl/core/telemetry_frame_receiver_unit.sv
// telemetry frame receiver, top level
// depends on trfr_pkg, trfr_parser and trfr_result_fifo
//
// input channel: one word per handshake (in_valid_i high, in_stall_o low),
// func_i = 0 carries a received byte in rx_byte_i, func_i = 1 is a receive
// timeout. output channel: one result word per handshake (out_valid_o high,
// out_stall_i low) with kind, point index and value, frame code, frame
// length, link mode and a last flag on the final result of an input word.
// throughput: one input word per cycle while in_stall_o is low. the parser
// updates its state in the cycle a word is accepted and writes zero, one or
// two results into a four-entry queue; a result is registered into the
// queue and offered from its head. a word giving two results (a point on
// the last byte of a frame) is read out as two result words, so the output
// port sets the long-run rate at one result a cycle. in_stall_o rises when
// the queue has less than two free entries, which happens only while the
// receiver stalls or after two-result words. reset clears the parser to
// hunting for sync and empties the queue; no clearing pass is needed.
module telemetry_frame_receiver_unit import trfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  point_index_o,
  output logic [31:0] point_value_o,
  output logic [7:0]  frame_code_o,
  output logic [9:0]  frame_bytes_o,
  output logic [1:0]  link_mode_o,
  output logic        last_o
);

  logic    full;
  logic    accept;
  logic    pop;
  push_t   push;
  result_t head;

  // handshakes
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;
  assign pop        = out_valid_o && !out_stall_i;

  trfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .func_i    (func_i),
    .rx_byte_i (rx_byte_i),
    .push_o    (push)
  );

  trfr_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  // result word fields
  assign kind_o        = head.kind;
  assign point_index_o = head.point_index;
  assign point_value_o = head.point_value;
  assign frame_code_o  = head.frame_code;
  assign frame_bytes_o = head.frame_bytes;
  assign link_mode_o   = head.link_mode;
  assign last_o        = head.last;

endmodule

### test/telemetry_frame_receiver_unit_tb.sv
// testbench for telemetry_frame_receiver_unit: sends bytes and timeouts, predicts the
// point updates, frame done and abort results and checks every result word
// depends on trfr_pkg and the rtl of telemetry_frame_receiver_unit
`timescale 1ns / 100ps

module telemetry_frame_receiver_unit_tb;
  import trfr_pkg::*;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        func_i      = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  point_index_o;
  logic [31:0] point_value_o;
  logic [7:0]  frame_code_o;
  logic [9:0]  frame_bytes_o;
  logic [1:0]  link_mode_o;
  logic        last_o;

  // idle rates in percent and bookkeeping
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned frame_words    = 0;
  int unsigned mismatch_count = 0;

  // results predicted but not yet seen on the output
  result_t pending_results[$];

  // predicted receiver state
  logic        rx_in_frame = 1'b0;
  logic [9:0]  rx_pos      = '0;
  logic [9:0]  rx_total    = '0;
  logic [7:0]  rx_code     = '0;
  logic [15:0] rx_count    = '0;
  logic [8:0]  rx_index    = '0;
  logic [31:0] rx_accum    = '0;
  logic [1:0]  rx_mode     = '0;

  telemetry_frame_receiver_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .point_index_o (point_index_o),
    .point_value_o (point_value_o),
    .frame_code_o  (frame_code_o),
    .frame_bytes_o (frame_bytes_o),
    .link_mode_o   (link_mode_o),
    .last_o        (last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t make_result(kind_e k, logic [7:0] idx, logic [31:0] val,
                                          logic [7:0] code, logic [9:0] nbytes,
                                          logic [1:0] mode);
    result_t r;
    r.kind        = k;
    r.point_index = idx;
    r.point_value = val;
    r.frame_code  = code;
    r.frame_bytes = nbytes;
    r.link_mode   = mode;
    r.last        = 1'b0;
    return r;
  endfunction

  // work out the results of one accepted word and queue them
  task automatic predict_frame_results(input logic f, input logic [7:0] b);
    result_t     res[$];
    logic [9:0]  pos;
    logic [9:0]  off;
    logic [2:0]  phase;
    int unsigned lim;
    if (f) begin
      // timeout aborts a partial frame, nothing while hunting
      if (rx_in_frame) begin
        res.push_back(make_result(KIND_ABORT, 8'd0, 32'd0, rx_code, rx_pos, 2'd0));
        rx_in_frame = 1'b0;
        rx_pos      = '0;
      end
    end else if (!rx_in_frame) begin
      if (b == SYNC_BYTE) begin
        rx_in_frame = 1'b1;
        rx_pos      = 10'd1;
        rx_total    = '0;
        rx_code     = '0;
        rx_count    = '0;
        rx_index    = '0;
        rx_accum    = '0;
      end
    end else begin
      pos = rx_pos;
      lim = rx_count;
      if (lim > MAX_POINTS) lim = MAX_POINTS;
      if (lim > INDEX_CAP) lim = INDEX_CAP;
      if (pos == POS_LEN_LO) begin
        rx_total = {2'b00, b};
      end else if (pos == POS_LEN_HI) begin
        rx_total = {1'b0, b[0], rx_total[7:0]} + LEN_EXTRA;
      end else if (pos == POS_CODE) begin
        rx_code = b;
      end else if (pos == POS_CNT_HI) begin
        rx_count = {b, 8'h00};
      end else if (pos == POS_CNT_LO) begin
        rx_count = {rx_count[15:8], b};
      end else if (pos >= POS_DATA) begin
        off = pos - POS_DATA;
        if (rx_code == CODE_DIGITAL) begin
          // one point per two bytes, top bit of the first
          if (!off[0] && rx_index < lim) begin
            res.push_back(make_result(KIND_DIGITAL, rx_index[7:0], {31'd0, b[7]},
                                      8'd0, 10'd0, 2'd0));
            rx_index++;
          end
        end else if (rx_code == CODE_ANALOG_A || rx_code == CODE_ANALOG_B) begin
          // six bytes per point, big-endian word in the first four
          phase = 3'(off % 6);
          if (phase == 3'd0) rx_accum = {24'd0, b};
          else if (phase < 3'd4) rx_accum = {rx_accum[23:0], b};
          if (phase == PHASE_WORD_END && rx_index < lim) begin
            res.push_back(make_result((rx_code == CODE_ANALOG_A) ? KIND_ANALOG_A
                                                                 : KIND_ANALOG_B,
                                      rx_index[7:0], rx_accum, 8'd0, 10'd0, 2'd0));
            rx_index++;
          end
        end
      end
      rx_pos = pos + 10'd1;
      // frame complete
      if (rx_pos >= POS_MIN_END && rx_pos == rx_total) begin
        if (rx_code == CODE_STARTUP) rx_mode = MODE_STARTUP;
        else if (rx_code == CODE_HEARTBEAT) rx_mode = MODE_HEARTBEAT;
        res.push_back(make_result(KIND_DONE, 8'd0, 32'd0, rx_code, rx_total, rx_mode));
        rx_in_frame = 1'b0;
        rx_pos      = '0;
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_results.push_back(res[i]);
  endtask

  // send one word, with random idle cycles ahead of it
  task automatic send_word(input logic f, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    predict_frame_results(f, b);
  endtask

  // hold the input off until every predicted result has come out
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // one frame of len + 6 bytes; a timeout follows if it is cut after cut bytes
  task automatic send_frame(input logic [7:0] code, input logic [15:0] count,
                            input logic [8:0] len, input int unsigned cut);
    int unsigned total;
    logic [7:0]  b;
    total = len + 6;
    for (int unsigned i = 0; i < total && i < cut; i++) begin
      case (i)
        0: b = SYNC_BYTE;
        1: b = len[7:0];
        2: b = {7'($urandom), len[8]};
        4: b = code;
        5: b = count[15:8];
        6: b = count[7:0];
        default: b = 8'($urandom);
      endcase
      send_word(1'b0, b);
      frame_words++;
    end
    if (cut < total) send_word(1'b1, 8'($urandom));
  endtask

  // frame with random code, size and count, sometimes cut short
  task automatic send_random_frame();
    logic [7:0]  code;
    logic [15:0] count;
    logic [8:0]  len;
    int unsigned pick;
    int unsigned total;
    int unsigned cut;
    pick = $urandom_range(9);
    case (pick)
      0, 1, 2: code = CODE_DIGITAL;
      3, 4:    code = CODE_ANALOG_A;
      5:       code = CODE_ANALOG_B;
      6:       code = CODE_HEARTBEAT;
      7:       code = CODE_STARTUP;
      default: code = 8'($urandom);
    endcase
    pick = $urandom_range(99);
    if (pick < 10) len = 9'($urandom_range(2));
    else if (pick < 85) len = 9'($urandom_range(40, 3));
    else len = 9'($urandom_range(120, 41));
    pick = $urandom_range(99);
    if (pick < 50) count = 16'($urandom_range(12));
    else if (pick < 70) count = 16'hFFFF;
    else count = 16'($urandom);
    total = len + 6;
    cut = total;
    if ($urandom_range(99) < 15) cut = $urandom_range(total - 1, 1);
    send_frame(code, count, len, cut);
  endtask

  // timeouts and junk while hunting give nothing
  task automatic test_hunting();
    send_word(1'b1, 8'hFF);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hFF);
    send_word(1'b1, SYNC_BYTE);
    wait_results_drained();
  endtask

  // shortest frames that switch the link mode
  task automatic test_mode_frames();
    send_frame(CODE_STARTUP, 16'd0, 9'd0, 6);
    send_frame(CODE_HEARTBEAT, 16'd0, 9'd0, 6);
    wait_results_drained();
  endtask

  // digital point on the final byte: update then frame done
  task automatic test_point_on_last_byte();
    send_frame(CODE_DIGITAL, 16'd1, 9'd4, 10);
    wait_results_drained();
  endtask

  // timeout right after sync and after the code byte
  task automatic test_abort();
    send_frame(8'h00, 16'd0, 9'd5, 1);
    send_frame(CODE_ANALOG_B, 16'd3, 9'd20, 5);
    wait_results_drained();
  endtask

  // longest frame the length field allows
  task automatic test_long_frames();
    send_frame(CODE_DIGITAL, 16'hFFFF, 9'h1FF, 1000);
    wait_results_drained();
  endtask

  // mostly well-formed frames, some noise and stray timeouts
  task automatic test_random_traffic(input int unsigned words);
    int unsigned start;
    int unsigned pick;
    start = frame_words;
    while (frame_words - start < words) begin
      pick = $urandom_range(99);
      if (pick < 80) send_random_frame();
      else if (pick < 90) send_word(1'b0, 8'($urandom));
      else send_word(1'b1, 8'($urandom));
    end
    wait_results_drained();
  endtask

  // compare one field of a result word
  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // check each result word against the oldest prediction, then pick the next stall
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d index %0d value 0x%0h",
                 $time, kind_o, point_index_o, point_value_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("point_index", 32'(want.point_index), 32'(point_index_o));
        check_field("point_value", want.point_value, point_value_o);
        check_field("frame_code", 32'(want.frame_code), 32'(frame_code_o));
        check_field("frame_bytes", 32'(want.frame_bytes), 32'(frame_bytes_o));
        check_field("link_mode", 32'(want.link_mode), 32'(link_mode_o));
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // run limit
  initial begin
    #(5_000_000);
    $display("telemetry_frame_receiver_unit_tb: errors");
    $finish;
  end

  // test sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 28;
    recv_stall_pct = 49;
    test_hunting();
    test_mode_frames();
    test_point_on_last_byte();
    test_abort();
    test_random_traffic(110);

    send_idle_pct  = 49;
    recv_stall_pct = 28;
    test_random_traffic(110);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_long_frames();
    test_random_traffic(110);

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("telemetry_frame_receiver_unit_tb: clean");
    end else begin
      $display("telemetry_frame_receiver_unit_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/trfr_pkg.sv
rtl/core/trfr_parser.sv
rtl/core/trfr_result_fifo.sv
rtl/core/telemetry_frame_receiver_unit.sv
test/telemetry_frame_receiver_unit_tb.sv
